### hw/rtl/rpn_pkg.sv
// shared types, codes and constants of the rpn stack calculator
package rpn_pkg;

  localparam int DATA_W          = 32;
  localparam int CMD_W           = 3;
  localparam int DEPTH_W         = 8;
  localparam int STATUS_W        = 2;
  localparam int STACK_DEPTH_DEF = 128;

  // commands
  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUP  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_INC  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_DEC  = 3'd7;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

  // alu operations
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_ADD = 2'd0;
  localparam alu_op_t ALU_SUB = 2'd1;
  localparam alu_op_t ALU_MUL = 2'd2;
  localparam alu_op_t ALU_DIV = 2'd3;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

endpackage

### hw/rtl/rpn_ram.sv
// generic single write port ram with registered read
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/rpn_alu.sv
// iterative alu: one shared 33-bit adder for add, sub, shift-add multiply and restoring divide
module rpn_alu (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rpn_pkg::alu_req_t         req,
  input  logic [rpn_pkg::DATA_W-1:0] opa,
  input  logic [rpn_pkg::DATA_W-1:0] opb,
  output logic                      done,
  output logic [rpn_pkg::DATA_W-1:0] result
);
  import rpn_pkg::*;

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MUL  = 2'd1;
  localparam logic [1:0] A_DIV  = 2'd2;
  localparam logic [1:0] A_NEG  = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] q_r, q_nxt;
  logic [DATA_W-1:0] m_r, m_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;

  logic [DATA_W-1:0] add_x, add_y;
  logic              add_sub;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] shifted;
  logic [DATA_W-1:0] acc_step;
  logic [DATA_W-1:0] q_step;
  logic [DATA_W-1:0] abs_a, abs_b;

  assign shifted = {acc_r[DATA_W-2:0], q_r[DATA_W-1]};
  assign abs_a   = opa[DATA_W-1] ? (DATA_W'(0) - opa) : opa;
  assign abs_b   = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;

  always_comb begin
    unique case (st_r)
      A_IDLE: begin
        add_x   = opa;
        add_y   = opb;
        add_sub = (req.op == ALU_SUB);
      end
      A_MUL: begin
        add_x   = acc_r;
        add_y   = m_r;
        add_sub = 1'b0;
      end
      A_DIV: begin
        add_x   = shifted;
        add_y   = m_r;
        add_sub = 1'b1;
      end
      default: begin
        add_x   = '0;
        add_y   = q_r;
        add_sub = 1'b1;
      end
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y ^ {DATA_W{add_sub}}} + (DATA_W+1)'(add_sub);

  // multiply step adds when the low multiplier bit is set, divide step keeps on no borrow
  assign acc_step = (st_r == A_MUL) ? (q_r[0] ? sum[DATA_W-1:0] : acc_r)
                                    : (sum[DATA_W] ? sum[DATA_W-1:0] : shifted);
  assign q_step   = {q_r[DATA_W-2:0], sum[DATA_W]};

  always_comb begin
    st_nxt   = st_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    unique case (st_r)
      A_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            ALU_ADD, ALU_SUB: begin
              res_nxt  = sum[DATA_W-1:0];
              done_nxt = 1'b1;
            end
            ALU_MUL: begin
              acc_nxt = '0;
              q_nxt   = opb;
              m_nxt   = opa;
              cnt_nxt = '0;
              st_nxt  = A_MUL;
            end
            default: begin
              acc_nxt = '0;
              q_nxt   = abs_a;
              m_nxt   = abs_b;
              neg_nxt = opa[DATA_W-1] ^ opb[DATA_W-1];
              cnt_nxt = '0;
              st_nxt  = A_DIV;
            end
          endcase
        end
      end
      A_MUL: begin
        acc_nxt = acc_step;
        m_nxt   = {m_r[DATA_W-2:0], 1'b0};
        q_nxt   = {1'b0, q_r[DATA_W-1:1]};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          res_nxt  = acc_step;
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      A_DIV: begin
        acc_nxt = acc_step;
        q_nxt   = q_step;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          if (neg_r) begin
            st_nxt = A_NEG;
          end else begin
            res_nxt  = q_step;
            done_nxt = 1'b1;
            st_nxt   = A_IDLE;
          end
        end
      end
      default: begin
        res_nxt  = sum[DATA_W-1:0];
        done_nxt = 1'b1;
        st_nxt   = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    m_r   <= m_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

### hw/rtl/rpn_stack_calculator_core.sv
// rpn stack calculator top level: stack control, top-of-stack register and result register
//
//  channel | ports                                             | direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid, in_stall, in_cmd, in_operand            | request in
//  out     | out_valid, out_stall, out_top_value, out_top_valid,| result out
//          | out_depth, out_status                             |
//
// push, dup, under- and overflow go idle to done; inc/dec pass the alu state, divide by zero
// the read state; add/sub/mul/div read, then alu (mul/div: 32 alu steps, one more to negate).
// the top of stack sits in a register, the entries below it in a ram with registered read.
// rst_n clears the stack count and handshake state; ram contents are left as they are.
// in_stall is high while a request is being worked; a stalled result is held in
// the output register and the next request may be taken meanwhile.
module rpn_stack_calculator_core #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rpn_pkg::CMD_W-1:0]     in_cmd,
  input  logic signed [rpn_pkg::DATA_W-1:0] in_operand,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [rpn_pkg::DATA_W-1:0] out_top_value,
  output logic                          out_top_valid,
  output logic [rpn_pkg::DEPTH_W-1:0]   out_depth,
  output logic [rpn_pkg::STATUS_W-1:0]  out_status
);
  import rpn_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_ALU  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          st_r, st_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [DATA_W-1:0]   tos_r, tos_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_value_r, out_value_nxt;
  logic                out_tv_r, out_tv_nxt;
  logic [DEPTH_W-1:0]  out_depth_r, out_depth_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                in_acc;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  alu_req_t            alu_req;
  logic [DATA_W-1:0]   alu_b;
  logic                alu_done;
  logic [DATA_W-1:0]   alu_result;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (st_r != S_IDLE);
  assign ram_waddr = AW'(cnt_r - CW'(1));
  assign ram_raddr = AW'(cnt_r - CW'(2));

  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    tos_nxt        = tos_r;
    cmd_nxt        = cmd_r;
    status_nxt     = status_r;
    ram_we         = 1'b0;
    alu_req.start  = 1'b0;
    alu_req.op     = ALU_ADD;
    alu_b          = ram_rdata;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_tv_nxt     = out_tv_r;
    out_depth_nxt  = out_depth_r;
    out_status_nxt = out_status_r;

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_cmd;
          status_nxt = ST_OK;
          st_nxt     = S_DONE;
          unique case (in_cmd)
            CMD_PUSH: begin
              if (cnt_r >= FULL) begin
                status_nxt = ST_OVER;
              end else begin
                ram_we  = (cnt_r != '0);
                tos_nxt = in_operand;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            CMD_DUP: begin
              if (cnt_r == '0) begin
                status_nxt = ST_UNDER;
              end else if (cnt_r >= FULL) begin
                status_nxt = ST_OVER;
              end else begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            CMD_INC, CMD_DEC: begin
              if (cnt_r == '0) begin
                status_nxt = ST_UNDER;
              end else begin
                alu_req.start = 1'b1;
                alu_req.op    = (in_cmd == CMD_INC) ? ALU_ADD : ALU_SUB;
                alu_b         = DATA_W'(1);
                st_nxt        = S_ALU;
              end
            end
            default: begin
              // binary ops: second operand is read from the ram
              if (cnt_r < CW'(2)) begin
                status_nxt = ST_UNDER;
              end else begin
                st_nxt = S_READ;
              end
            end
          endcase
        end
      end
      S_READ: begin
        if (cmd_r == CMD_DIV && ram_rdata == '0) begin
          status_nxt = ST_DIVZ;
          st_nxt     = S_DONE;
        end else begin
          alu_req.start = 1'b1;
          unique case (cmd_r)
            CMD_ADD: alu_req.op = ALU_ADD;
            CMD_SUB: alu_req.op = ALU_SUB;
            CMD_MUL: alu_req.op = ALU_MUL;
            default: alu_req.op = ALU_DIV;
          endcase
          st_nxt = S_ALU;
        end
      end
      S_ALU: begin
        if (alu_done) begin
          tos_nxt = alu_result;
          if (cmd_r != CMD_INC && cmd_r != CMD_DEC) begin
            cnt_nxt = cnt_r - CW'(1);
          end
          st_nxt = S_DONE;
        end
      end
      default: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_tv_nxt     = (cnt_r != '0);
          out_value_nxt  = (cnt_r != '0) ? tos_r : '0;
          out_depth_nxt  = DEPTH_W'(cnt_r);
          out_status_nxt = status_r;
          st_nxt         = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tos_r        <= tos_nxt;
    cmd_r        <= cmd_nxt;
    status_r     <= status_nxt;
    out_value_r  <= out_value_nxt;
    out_tv_r     <= out_tv_nxt;
    out_depth_r  <= out_depth_nxt;
    out_status_r <= out_status_nxt;
  end

  rpn_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(tos_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rpn_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (tos_r),
    .opb   (alu_b),
    .done  (alu_done),
    .result(alu_result)
  );

  assign out_valid     = out_valid_r;
  assign out_top_value = out_value_r;
  assign out_top_valid = out_tv_r;
  assign out_depth     = out_depth_r;
  assign out_status    = out_status_r;

endmodule
